FILE: hw/rtl/usb_control_request_responder_core_defines.svh
// ----------------------------------------------------------------------------
// usb control request responder assertion macros
// concurrent property shorthands shared by the checker
// ----------------------------------------------------------------------------
`ifndef USB_CONTROL_REQUEST_RESPONDER_CORE_DEFINES_SVH
`define USB_CONTROL_REQUEST_RESPONDER_CORE_DEFINES_SVH

// same-cycle implication under reset
`define USBCR_ASSERT_HOLDS(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("usbcr: property violated");

// next-cycle implication under reset
`define USBCR_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("usbcr: property violated");

`endif

FILE: hw/rtl/usbcr_pkg.sv
// ----------------------------------------------------------------------------
// usbcr_pkg
// types, codes and constants of the usb control request responder
// ----------------------------------------------------------------------------
package usbcr_pkg;

    localparam int unsigned QueueDepth = 2;
    localparam int unsigned CfgIdxW    = 3;
    localparam int unsigned STdataW    = 64;
    localparam int unsigned MTdataW    = 72;

    // config register indexes
    localparam logic [CfgIdxW-1:0] CFG_DEVICE_DESC_LEN    = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_CONFIG_TOTAL_LEN   = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_QUALIFIER_DESC_LEN = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_HID_DESC_LEN       = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_REPORT_DESC_LEN    = 3'd4;
    localparam logic [CfgIdxW-1:0] CFG_MAKER_STRING_LEN   = 3'd5;
    localparam logic [CfgIdxW-1:0] CFG_PRODUCT_STRING_LEN = 3'd6;

    localparam logic [7:0] RST_DEVICE_DESC_LEN    = 8'd18;
    localparam logic [7:0] RST_CONFIG_TOTAL_LEN   = 8'd34;
    localparam logic [7:0] RST_QUALIFIER_DESC_LEN = 8'd10;
    localparam logic [7:0] RST_HID_DESC_LEN       = 8'd9;
    localparam logic [7:0] RST_REPORT_DESC_LEN    = 8'd22;
    localparam logic [7:0] RST_MAKER_STRING_LEN   = 8'd40;
    localparam logic [7:0] RST_PRODUCT_STRING_LEN = 8'd56;
    localparam logic [7:0] LANG_ID_LEN            = 8'd4;
    localparam logic [7:0] ZERO_WORD_LEN          = 8'd2;
    localparam logic [7:0] CONFIG_BYTE_LEN        = 8'd1;
    localparam logic [7:0] VENDOR_WORD_LEN        = 8'd4;
    localparam logic [7:0] VENDOR_BYTE_LEN        = 8'd1;

    // bmRequestType type bits and recipients
    localparam logic [1:0] RT_STANDARD = 2'd0;
    localparam logic [1:0] RT_CLASS    = 2'd1;
    localparam logic [1:0] RT_VENDOR   = 2'd2;
    localparam logic [4:0] RCP_DEVICE    = 5'd0;
    localparam logic [4:0] RCP_INTERFACE = 5'd1;
    localparam logic [4:0] RCP_ENDPOINT  = 5'd2;

    // standard and class request codes
    localparam logic [7:0] REQ_GET_STATUS     = 8'h00;
    localparam logic [7:0] REQ_CLEAR_FEATURE  = 8'h01;
    localparam logic [7:0] REQ_SET_FEATURE    = 8'h03;
    localparam logic [7:0] REQ_SET_ADDRESS    = 8'h05;
    localparam logic [7:0] REQ_GET_DESCRIPTOR = 8'h06;
    localparam logic [7:0] REQ_GET_CONFIG     = 8'h08;
    localparam logic [7:0] REQ_SET_CONFIG     = 8'h09;
    localparam logic [7:0] REQ_SET_IDLE       = 8'h0A;

    // vendor request codes
    localparam logic [7:0] VND_QUERY_A  = 8'h00;
    localparam logic [7:0] VND_QUERY_B  = 8'h01;
    localparam logic [7:0] VND_WRITE_A  = 8'h02;
    localparam logic [7:0] VND_NOTIFY   = 8'h03;
    localparam logic [7:0] VND_WRITE_B  = 8'h04;
    localparam logic [7:0] VND_READ_A   = 8'h05;
    localparam logic [7:0] VND_WRITE_C  = 8'h06;
    localparam logic [7:0] VND_READ_B   = 8'h07;

    // descriptor types and string indexes
    localparam logic [7:0] DESC_DEVICE    = 8'h01;
    localparam logic [7:0] DESC_CONFIG    = 8'h02;
    localparam logic [7:0] DESC_STRING    = 8'h03;
    localparam logic [7:0] DESC_QUALIFIER = 8'h06;
    localparam logic [7:0] DESC_HID       = 8'h21;
    localparam logic [7:0] DESC_REPORT    = 8'h22;
    localparam logic [7:0] STR_LANG_ID    = 8'h00;
    localparam logic [7:0] STR_MAKER      = 8'h01;
    localparam logic [7:0] STR_PRODUCT    = 8'h02;

    localparam logic [15:0] CONFIG_NONE = 16'd0;
    localparam logic [15:0] CONFIG_ONE  = 16'd1;

    typedef enum logic [1:0] {
        OP_SETUP     = 2'd0,
        OP_IN_DONE   = 2'd1,
        OP_BUS_RESET = 2'd2,
        OP_UNUSED    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        RESP_NONE   = 2'd0,
        RESP_STALL  = 2'd1,
        RESP_STATUS = 2'd2,
        RESP_DATA   = 2'd3
    } resp_kind_t;

    typedef enum logic [3:0] {
        SRC_NONE        = 4'd0,
        SRC_DEV         = 4'd1,
        SRC_CFG         = 4'd2,
        SRC_LANG        = 4'd3,
        SRC_MAKER       = 4'd4,
        SRC_PRODUCT     = 4'd5,
        SRC_QUAL        = 4'd6,
        SRC_HID         = 4'd7,
        SRC_REPORT      = 4'd8,
        SRC_ZERO_WORD   = 4'd9,
        SRC_CONFIG_BYTE = 4'd10,
        SRC_VENDOR      = 4'd11
    } data_src_t;

    typedef enum logic [2:0] {
        EP0_IDLE       = 3'd0,
        EP0_SETUP      = 3'd1,
        EP0_DATA_IN    = 3'd2,
        EP0_STATUS_OUT = 3'd3,
        EP0_STATUS_IN  = 3'd4
    } ep0_phase_t;

    typedef enum logic [1:0] {
        DEV_DEFAULT    = 2'd0,
        DEV_ADDRESSED  = 2'd1,
        DEV_CONFIGURED = 2'd2
    } dev_phase_t;

    typedef enum logic [3:0] {
        ACT_NOP         = 4'd0,
        ACT_RESPOND     = 4'd1,
        ACT_SET_ADDRESS = 4'd2,
        ACT_GET_CONFIG  = 4'd3,
        ACT_SET_CONFIG0 = 4'd4,
        ACT_SET_CONFIG1 = 4'd5,
        ACT_EP_FEATURE  = 4'd6,
        ACT_IN_DONE     = 4'd7,
        ACT_BUS_RESET   = 4'd8
    } act_t;

    // classified command between front and back
    typedef struct packed {
        act_t        act;
        resp_kind_t  kind;
        data_src_t   src;
        logic [7:0]  len;
        logic [6:0]  addr;
        logic [7:0]  vendor_code;
        logic [15:0] vendor_value;
        logic [15:0] vendor_index;
    } cmd_t;

    // result item body, last field in the lowest bits
    typedef struct packed {
        logic [15:0] vendor_index;
        logic [15:0] vendor_value;
        logic [7:0]  vendor_code;
        logic        open_interrupt_ep;
        logic        active_config;
        logic [6:0]  bus_address;
        dev_phase_t  device_phase;
        ep0_phase_t  control_phase;
        logic [7:0]  data_length;
        data_src_t   data_source;
    } result_t;

    localparam int unsigned ResultW = $bits(result_t);

endpackage

FILE: hw/rtl/usb_control_request_responder_core.sv
// Control endpoint responder of a USB HID device. Each input item is a setup
// packet, an EP0 IN completion or a bus reset; each gives exactly one result
// item with the response (none, stall, zero-length status or data with source
// and length) and the control phase, device state, address and configuration
// after the event. One item is accepted per clock while s_tready is high: the
// front classifies the request against the descriptor length registers, a
// queue of QUEUE_DEPTH commands decouples it from the back, which updates the
// state and loads the result register. A result passes through a queue entry
// and then the result register before it is presented; while a result is held
// by m_tready the queue takes up to QUEUE_DEPTH more items before s_tready drops.
// The configuration port is always ready and takes every write.
// ----------------------------------------------------------------------------
// usb_control_request_responder_core
// top level: front classifier, command queue and state back end
// ----------------------------------------------------------------------------
module usb_control_request_responder_core #(
    parameter int unsigned QUEUE_DEPTH = usbcr_pkg::QueueDepth
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // request_type, request_code, request_value, request_index, request_length
    input  logic [usbcr_pkg::STdataW-1:0]   s_tdata,
    // operation
    input  logic [1:0]                      s_tuser,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // data_source, data_length, control_phase, device_phase, bus_address,
    // active_config, open_interrupt_ep, vendor_code, vendor_value, vendor_index
    output logic [usbcr_pkg::MTdataW-1:0]   m_tdata,
    // response_kind
    output logic [1:0]                      m_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [usbcr_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [7:0]                      cfg_data
);

    usbcr_pkg::cmd_t front_cmd, back_cmd;
    logic            front_valid, front_ready;
    logic            back_valid, back_ready;

    usbcr_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_valid (front_valid),
        .cmd_ready (front_ready),
        .cmd       (front_cmd)
    );

    usbcr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_cmd    (front_cmd),
        .out_valid (back_valid),
        .out_ready (back_ready),
        .out_cmd   (back_cmd)
    );

    usbcr_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (back_valid),
        .cmd_ready (back_ready),
        .cmd       (back_cmd),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

FILE: hw/rtl/usbcr_front.sv
// ----------------------------------------------------------------------------
// usbcr_front
// accepts events, holds descriptor lengths and classifies setup requests
// ----------------------------------------------------------------------------
module usbcr_front (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [usbcr_pkg::STdataW-1:0]    s_tdata,
    input  logic [1:0]                       s_tuser,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [usbcr_pkg::CfgIdxW-1:0]    cfg_index,
    input  logic [7:0]                       cfg_data,
    output logic                             cmd_valid,
    input  logic                             cmd_ready,
    output usbcr_pkg::cmd_t                  cmd
);

    logic [7:0] dev_len_reg, cfg_len_reg, qual_len_reg, hid_len_reg;
    logic [7:0] report_len_reg, maker_len_reg, product_len_reg;

    usbcr_pkg::op_t op;
    logic [1:0]     rt_kind;
    logic [4:0]     rt_recip;
    logic [7:0]     code;
    logic [15:0]    value;
    logic [15:0]    windex;
    logic [15:0]    wlength;
    logic [7:0]     dtype;
    logic [7:0]     didx;

    logic                 desc_hit;
    usbcr_pkg::data_src_t desc_src;
    logic [7:0]           desc_len;
    logic [7:0]           clip_len;

    assign op       = usbcr_pkg::op_t'(s_tuser);
    assign rt_kind  = s_tdata[6:5];
    assign rt_recip = s_tdata[4:0];
    assign code     = s_tdata[15:8];
    assign value    = s_tdata[31:16];
    assign windex   = s_tdata[47:32];
    assign wlength  = s_tdata[63:48];
    assign dtype    = value[15:8];
    assign didx     = value[7:0];

    assign s_tready  = cmd_ready;
    assign cmd_valid = s_tvalid;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dev_len_reg     <= usbcr_pkg::RST_DEVICE_DESC_LEN;
            cfg_len_reg     <= usbcr_pkg::RST_CONFIG_TOTAL_LEN;
            qual_len_reg    <= usbcr_pkg::RST_QUALIFIER_DESC_LEN;
            hid_len_reg     <= usbcr_pkg::RST_HID_DESC_LEN;
            report_len_reg  <= usbcr_pkg::RST_REPORT_DESC_LEN;
            maker_len_reg   <= usbcr_pkg::RST_MAKER_STRING_LEN;
            product_len_reg <= usbcr_pkg::RST_PRODUCT_STRING_LEN;
        end else if (cfg_valid) begin
            case (cfg_index)
                usbcr_pkg::CFG_DEVICE_DESC_LEN:    dev_len_reg     <= cfg_data;
                usbcr_pkg::CFG_CONFIG_TOTAL_LEN:   cfg_len_reg     <= cfg_data;
                usbcr_pkg::CFG_QUALIFIER_DESC_LEN: qual_len_reg    <= cfg_data;
                usbcr_pkg::CFG_HID_DESC_LEN:       hid_len_reg     <= cfg_data;
                usbcr_pkg::CFG_REPORT_DESC_LEN:    report_len_reg  <= cfg_data;
                usbcr_pkg::CFG_MAKER_STRING_LEN:   maker_len_reg   <= cfg_data;
                usbcr_pkg::CFG_PRODUCT_STRING_LEN: product_len_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // descriptor lookup
    always_comb begin
        desc_hit = 1'b0;
        desc_src = usbcr_pkg::SRC_NONE;
        desc_len = '0;
        if (code == usbcr_pkg::REQ_GET_DESCRIPTOR && rt_kind == usbcr_pkg::RT_STANDARD) begin
            if (rt_recip == usbcr_pkg::RCP_DEVICE) begin
                if (dtype == usbcr_pkg::DESC_DEVICE) begin
                    desc_hit = 1'b1;
                    desc_src = usbcr_pkg::SRC_DEV;
                    desc_len = dev_len_reg;
                end else if (dtype == usbcr_pkg::DESC_CONFIG) begin
                    desc_hit = 1'b1;
                    desc_src = usbcr_pkg::SRC_CFG;
                    desc_len = cfg_len_reg;
                end else if (dtype == usbcr_pkg::DESC_QUALIFIER) begin
                    desc_hit = 1'b1;
                    desc_src = usbcr_pkg::SRC_QUAL;
                    desc_len = qual_len_reg;
                end else if (dtype == usbcr_pkg::DESC_STRING) begin
                    case (didx)
                        usbcr_pkg::STR_LANG_ID: begin
                            desc_hit = 1'b1;
                            desc_src = usbcr_pkg::SRC_LANG;
                            desc_len = usbcr_pkg::LANG_ID_LEN;
                        end
                        usbcr_pkg::STR_MAKER: begin
                            desc_hit = 1'b1;
                            desc_src = usbcr_pkg::SRC_MAKER;
                            desc_len = maker_len_reg;
                        end
                        usbcr_pkg::STR_PRODUCT: begin
                            desc_hit = 1'b1;
                            desc_src = usbcr_pkg::SRC_PRODUCT;
                            desc_len = product_len_reg;
                        end
                        default: ;
                    endcase
                end
            end else if (rt_recip == usbcr_pkg::RCP_INTERFACE) begin
                if (dtype == usbcr_pkg::DESC_REPORT) begin
                    desc_hit = 1'b1;
                    desc_src = usbcr_pkg::SRC_REPORT;
                    desc_len = report_len_reg;
                end else if (dtype == usbcr_pkg::DESC_HID) begin
                    desc_hit = 1'b1;
                    desc_src = usbcr_pkg::SRC_HID;
                    desc_len = hid_len_reg;
                end
            end
        end
    end

    // clip to wLength
    assign clip_len = (wlength < {8'd0, desc_len}) ? wlength[7:0] : desc_len;

    always_comb begin
        cmd      = '0;
        cmd.act  = usbcr_pkg::ACT_NOP;
        cmd.kind = usbcr_pkg::RESP_NONE;
        cmd.src  = usbcr_pkg::SRC_NONE;
        case (op)
            usbcr_pkg::OP_SETUP: begin
                cmd.act  = usbcr_pkg::ACT_RESPOND;
                cmd.kind = usbcr_pkg::RESP_STALL;
                if (desc_hit) begin
                    if (clip_len == 8'd0) begin
                        cmd.kind = usbcr_pkg::RESP_STATUS;
                    end else begin
                        cmd.kind = usbcr_pkg::RESP_DATA;
                        cmd.src  = desc_src;
                        cmd.len  = clip_len;
                    end
                end else if (rt_kind == usbcr_pkg::RT_STANDARD
                             && rt_recip == usbcr_pkg::RCP_DEVICE) begin
                    case (code)
                        usbcr_pkg::REQ_GET_STATUS: begin
                            cmd.kind = usbcr_pkg::RESP_DATA;
                            cmd.src  = usbcr_pkg::SRC_ZERO_WORD;
                            cmd.len  = usbcr_pkg::ZERO_WORD_LEN;
                        end
                        usbcr_pkg::REQ_SET_ADDRESS: begin
                            cmd.act  = usbcr_pkg::ACT_SET_ADDRESS;
                            cmd.addr = value[6:0];
                        end
                        usbcr_pkg::REQ_GET_CONFIG: cmd.act = usbcr_pkg::ACT_GET_CONFIG;
                        usbcr_pkg::REQ_SET_CONFIG: begin
                            if (value == usbcr_pkg::CONFIG_NONE) begin
                                cmd.act = usbcr_pkg::ACT_SET_CONFIG0;
                            end else if (value == usbcr_pkg::CONFIG_ONE) begin
                                cmd.act = usbcr_pkg::ACT_SET_CONFIG1;
                            end
                        end
                        default: ;
                    endcase
                end else if (rt_kind == usbcr_pkg::RT_STANDARD
                             && rt_recip == usbcr_pkg::RCP_ENDPOINT) begin
                    case (code)
                        usbcr_pkg::REQ_GET_STATUS: begin
                            cmd.kind = usbcr_pkg::RESP_DATA;
                            cmd.src  = usbcr_pkg::SRC_ZERO_WORD;
                            cmd.len  = usbcr_pkg::ZERO_WORD_LEN;
                        end
                        usbcr_pkg::REQ_CLEAR_FEATURE: cmd.act = usbcr_pkg::ACT_EP_FEATURE;
                        usbcr_pkg::REQ_SET_FEATURE:   cmd.kind = usbcr_pkg::RESP_STATUS;
                        default: ;
                    endcase
                end else if (rt_kind == usbcr_pkg::RT_CLASS
                             && rt_recip == usbcr_pkg::RCP_INTERFACE) begin
                    if (code == usbcr_pkg::REQ_SET_IDLE) begin
                        cmd.kind = usbcr_pkg::RESP_STATUS;
                    end
                end else if (rt_kind == usbcr_pkg::RT_VENDOR
                             && rt_recip == usbcr_pkg::RCP_DEVICE) begin
                    cmd.vendor_code  = code;
                    cmd.vendor_value = value;
                    cmd.vendor_index = windex;
                    case (code) inside
                        usbcr_pkg::VND_QUERY_A, usbcr_pkg::VND_QUERY_B: begin
                            cmd.kind = usbcr_pkg::RESP_DATA;
                            cmd.src  = usbcr_pkg::SRC_VENDOR;
                            cmd.len  = usbcr_pkg::VENDOR_WORD_LEN;
                        end
                        usbcr_pkg::VND_WRITE_A, usbcr_pkg::VND_WRITE_B,
                        usbcr_pkg::VND_WRITE_C: begin
                            cmd.kind = usbcr_pkg::RESP_STATUS;
                        end
                        usbcr_pkg::VND_NOTIFY: cmd.kind = usbcr_pkg::RESP_NONE;
                        usbcr_pkg::VND_READ_A, usbcr_pkg::VND_READ_B: begin
                            cmd.kind = usbcr_pkg::RESP_DATA;
                            cmd.src  = usbcr_pkg::SRC_VENDOR;
                            cmd.len  = usbcr_pkg::VENDOR_BYTE_LEN;
                        end
                        default: ;
                    endcase
                end
            end
            usbcr_pkg::OP_IN_DONE:   cmd.act = usbcr_pkg::ACT_IN_DONE;
            usbcr_pkg::OP_BUS_RESET: cmd.act = usbcr_pkg::ACT_BUS_RESET;
            default: ;
        endcase
    end

endmodule

FILE: hw/rtl/usbcr_queue.sv
// ----------------------------------------------------------------------------
// usbcr_queue
// short command queue between the front and the back
// ----------------------------------------------------------------------------
module usbcr_queue #(
    parameter int unsigned DEPTH = usbcr_pkg::QueueDepth
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  usbcr_pkg::cmd_t in_cmd,
    output logic            out_valid,
    input  logic            out_ready,
    output usbcr_pkg::cmd_t out_cmd
);

    localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

    usbcr_pkg::cmd_t entry_reg [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;
    logic            push, pop;

    assign in_ready  = (count_reg != FullCnt);
    assign out_valid = (count_reg != '0);
    assign out_cmd   = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

FILE: hw/rtl/usbcr_back.sv
// ----------------------------------------------------------------------------
// usbcr_back
// applies commands to the ep0 and device state and registers each result
// ----------------------------------------------------------------------------
module usbcr_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cmd_valid,
    output logic                           cmd_ready,
    input  usbcr_pkg::cmd_t                cmd,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [usbcr_pkg::MTdataW-1:0]  m_tdata,
    output logic [1:0]                     m_tuser
);

    usbcr_pkg::ep0_phase_t ep0_reg, ep0_next;
    usbcr_pkg::dev_phase_t dev_reg, dev_next;
    logic [6:0]            live_addr_reg, live_addr_next;
    logic [6:0]            pend_addr_reg, pend_addr_next;
    logic                  cfg_val_reg, cfg_val_next;
    logic                  out_valid_reg, out_valid_next;
    usbcr_pkg::result_t    res_reg, res_next;
    usbcr_pkg::resp_kind_t kind_reg, kind_next;

    usbcr_pkg::resp_kind_t rk;
    usbcr_pkg::data_src_t  rsrc;
    logic [7:0]            rlen;
    logic                  ropen;
    logic                  take;

    assign cmd_ready = !out_valid_reg || m_tready;
    assign take      = cmd_valid && cmd_ready;
    assign m_tvalid  = out_valid_reg;
    assign m_tuser   = kind_reg;
    assign m_tdata   = {{(usbcr_pkg::MTdataW - usbcr_pkg::ResultW){1'b0}}, res_reg};

    always_comb begin
        ep0_next       = ep0_reg;
        dev_next       = dev_reg;
        live_addr_next = live_addr_reg;
        pend_addr_next = pend_addr_reg;
        cfg_val_next   = cfg_val_reg;
        out_valid_next = out_valid_reg && !m_tready;
        res_next       = res_reg;
        kind_next      = kind_reg;
        rk             = usbcr_pkg::RESP_STALL;
        rsrc           = usbcr_pkg::SRC_NONE;
        rlen           = '0;
        ropen          = 1'b0;
        if (take) begin
            out_valid_next = 1'b1;
            ep0_next       = usbcr_pkg::EP0_SETUP;
            case (cmd.act)
                usbcr_pkg::ACT_RESPOND: begin
                    rk   = cmd.kind;
                    rsrc = cmd.src;
                    rlen = cmd.len;
                    case (cmd.kind)
                        usbcr_pkg::RESP_DATA:   ep0_next = usbcr_pkg::EP0_DATA_IN;
                        usbcr_pkg::RESP_STATUS: ep0_next = usbcr_pkg::EP0_STATUS_IN;
                        default:                ep0_next = usbcr_pkg::EP0_SETUP;
                    endcase
                end
                usbcr_pkg::ACT_SET_ADDRESS: begin
                    if (dev_reg != usbcr_pkg::DEV_CONFIGURED) begin
                        if (cmd.addr == '0) begin
                            live_addr_next = '0;
                            pend_addr_next = '0;
                            dev_next       = usbcr_pkg::DEV_DEFAULT;
                        end else begin
                            pend_addr_next = cmd.addr;
                            dev_next       = usbcr_pkg::DEV_ADDRESSED;
                        end
                        rk       = usbcr_pkg::RESP_STATUS;
                        ep0_next = usbcr_pkg::EP0_STATUS_IN;
                    end
                end
                usbcr_pkg::ACT_GET_CONFIG: begin
                    if (dev_reg != usbcr_pkg::DEV_DEFAULT) begin
                        if (dev_reg == usbcr_pkg::DEV_ADDRESSED) begin
                            cfg_val_next = 1'b0;
                        end
                        rk       = usbcr_pkg::RESP_DATA;
                        rsrc     = usbcr_pkg::SRC_CONFIG_BYTE;
                        rlen     = usbcr_pkg::CONFIG_BYTE_LEN;
                        ep0_next = usbcr_pkg::EP0_DATA_IN;
                    end
                end
                usbcr_pkg::ACT_SET_CONFIG0: begin
                    cfg_val_next = 1'b0;
                    dev_next     = usbcr_pkg::DEV_ADDRESSED;
                    rk           = usbcr_pkg::RESP_STATUS;
                    ep0_next     = usbcr_pkg::EP0_STATUS_IN;
                end
                usbcr_pkg::ACT_SET_CONFIG1: begin
                    cfg_val_next = 1'b1;
                    ropen        = 1'b1;
                    dev_next     = usbcr_pkg::DEV_CONFIGURED;
                    rk           = usbcr_pkg::RESP_STATUS;
                    ep0_next     = usbcr_pkg::EP0_STATUS_IN;
                end
                usbcr_pkg::ACT_EP_FEATURE: begin
                    if (dev_reg == usbcr_pkg::DEV_CONFIGURED) begin
                        rk       = usbcr_pkg::RESP_STATUS;
                        ep0_next = usbcr_pkg::EP0_STATUS_IN;
                    end
                end
                usbcr_pkg::ACT_IN_DONE: begin
                    rk       = usbcr_pkg::RESP_NONE;
                    ep0_next = (ep0_reg == usbcr_pkg::EP0_DATA_IN)
                             ? usbcr_pkg::EP0_STATUS_OUT : usbcr_pkg::EP0_IDLE;
                    if (pend_addr_reg != '0) begin
                        live_addr_next = pend_addr_reg;
                        pend_addr_next = '0;
                    end
                end
                usbcr_pkg::ACT_BUS_RESET: begin
                    rk             = usbcr_pkg::RESP_NONE;
                    ep0_next       = usbcr_pkg::EP0_IDLE;
                    dev_next       = usbcr_pkg::DEV_DEFAULT;
                    live_addr_next = '0;
                    pend_addr_next = '0;
                    cfg_val_next   = 1'b0;
                end
                default: begin
                    // unused operation leaves the state alone
                    rk       = usbcr_pkg::RESP_NONE;
                    ep0_next = ep0_reg;
                end
            endcase
            kind_next                  = rk;
            res_next.data_source       = rsrc;
            res_next.data_length       = rlen;
            res_next.control_phase     = ep0_next;
            res_next.device_phase      = dev_next;
            res_next.bus_address       = live_addr_next;
            res_next.active_config     = cfg_val_next;
            res_next.open_interrupt_ep = ropen;
            res_next.vendor_code       = cmd.vendor_code;
            res_next.vendor_value      = cmd.vendor_value;
            res_next.vendor_index      = cmd.vendor_index;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ep0_reg       <= usbcr_pkg::EP0_IDLE;
            dev_reg       <= usbcr_pkg::DEV_DEFAULT;
            live_addr_reg <= '0;
            pend_addr_reg <= '0;
            cfg_val_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            ep0_reg       <= ep0_next;
            dev_reg       <= dev_next;
            live_addr_reg <= live_addr_next;
            pend_addr_reg <= pend_addr_next;
            cfg_val_reg   <= cfg_val_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg  <= res_next;
        kind_reg <= kind_next;
    end

endmodule

FILE: hw/rtl/usbcr_checker.sv
// ----------------------------------------------------------------------------
// usbcr_checker
// port-level checks of the responder, bound to the top level
// ----------------------------------------------------------------------------
`include "usb_control_request_responder_core_defines.svh"

module usbcr_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic [usbcr_pkg::STdataW-1:0]   s_tdata,
    input logic [1:0]                      s_tuser,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [usbcr_pkg::MTdataW-1:0]   m_tdata,
    input logic [1:0]                      m_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic                            cfg_valid,
    input logic                            cfg_ready,
    input logic [usbcr_pkg::CfgIdxW-1:0]   cfg_index,
    input logic [7:0]                      cfg_data
);

    // a stalled result item holds
    `USBCR_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // only data responses carry a length
    `USBCR_ASSERT_HOLDS(a_len_only_data, aclk, aresetn, m_tvalid && m_tuser != usbcr_pkg::RESP_DATA, m_tdata[11:4] == 8'd0)

    // a stall leaves ep0 in the setup phase
    `USBCR_ASSERT_HOLDS(a_stall_setup, aclk, aresetn, m_tvalid && m_tuser == usbcr_pkg::RESP_STALL, m_tdata[14:12] == usbcr_pkg::EP0_SETUP)

    // opening the interrupt endpoint comes with configuration one
    `USBCR_ASSERT_HOLDS(a_open_configured, aclk, aresetn, m_tvalid && m_tdata[25], m_tdata[24] && m_tdata[16:15] == usbcr_pkg::DEV_CONFIGURED && m_tuser == usbcr_pkg::RESP_STATUS)

endmodule

bind usb_control_request_responder_core usbcr_checker u_usbcr_checker (.*);
